[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL modules of the block allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, disabled while rst_ni is low.
`define KVBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: antecedent on one edge, consequent on the same edge.
`define KVBA_ASSERT_IMP(lbl, ante, cons, msg) \
  `KVBA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/core/kvba_pkg.sv]
// Package with constants, codes and types of the block allocator.
`default_nettype none
package kvba_pkg;

  localparam int NUM_BLOCKS  = 1024;
  localparam int MAP_ENTRIES = 1024;

  localparam int ID_W   = 12;
  localparam int KEY_W  = 64;
  localparam int TOK_W  = 32;
  localparam int RC_W   = 16;
  localparam int STAT_W = 2;
  localparam int CMD_W  = 3;

  localparam int BLK_AW = $clog2(NUM_BLOCKS);
  localparam int MAP_AW = $clog2(MAP_ENTRIES);
  localparam int FC_W   = $clog2(NUM_BLOCKS + 1);
  localparam int CLR_N  = (NUM_BLOCKS > MAP_ENTRIES) ? NUM_BLOCKS : MAP_ENTRIES;
  localparam int CLR_AW = $clog2(CLR_N);

  localparam logic [RC_W-1:0] RC_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_REF    = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_INSERT = 3'd4,
    CMD_HASH   = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_IGN  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_HASH,
    S_STK_DATA,
    S_BLK_DATA,
    S_SCAN_WAIT,
    S_LK_DATA,
    S_FREE_FIN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [BLK_AW-1:0] blk;
    logic [KEY_W-1:0]  key;
  } map_entry_t;

  typedef struct packed {
    logic [RC_W-1:0]  cnt;
    logic [KEY_W-1:0] hash;
  } blk_entry_t;

  typedef struct packed {
    logic              hit;
    logic [MAP_AW-1:0] hit_idx;
    logic [BLK_AW-1:0] hit_blk;
    logic              free_ok;
    logic [MAP_AW-1:0] free_idx;
  } scan_res_t;

endpackage
`default_nettype wire

[rtl/core/kvba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kvba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/core/kvba_scan.sv]
// Map scanner: one comparator walks all map entries for a key and a free slot.
`default_nettype none
`include "assert_macros.svh"
module kvba_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [kvba_pkg::KEY_W-1:0]     key_i,
  output logic [kvba_pkg::MAP_AW-1:0]    rd_addr_o,
  input  kvba_pkg::map_entry_t           rd_data_i,
  output logic                           done_o,
  output kvba_pkg::scan_res_t            res_o
);
  import kvba_pkg::*;

  logic              busy_q, busy_d;
  logic              chk_q, chk_d;
  logic              done_q, done_d;
  logic [MAP_AW-1:0] addr_q, addr_d;
  logic [MAP_AW-1:0] chk_idx_q, chk_idx_d;
  logic [KEY_W-1:0]  key_q, key_d;
  scan_res_t         res_q, res_d;

  always_comb begin
    busy_d    = busy_q;
    addr_d    = addr_q;
    key_d     = key_q;
    res_d     = res_q;
    chk_d     = busy_q;
    chk_idx_d = addr_q;
    done_d    = chk_q && !busy_q;
    if (start_i) begin
      busy_d = 1'b1;
      addr_d = '0;
      key_d  = key_i;
      res_d  = '0;
    end else begin
      if (busy_q) begin
        addr_d = addr_q + 1'b1;
        if (addr_q == MAP_AW'(MAP_ENTRIES - 1)) begin
          busy_d = 1'b0;
        end
      end
      // The first matching entry and the first empty entry are kept.
      if (chk_q) begin
        if (!res_q.hit && rd_data_i.valid && (rd_data_i.key == key_q)) begin
          res_d.hit     = 1'b1;
          res_d.hit_idx = chk_idx_q;
          res_d.hit_blk = rd_data_i.blk;
        end
        if (!res_q.free_ok && !rd_data_i.valid) begin
          res_d.free_ok  = 1'b1;
          res_d.free_idx = chk_idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chk_q  <= 1'b0;
      done_q <= 1'b0;
      addr_q <= '0;
    end else begin
      busy_q <= busy_d;
      chk_q  <= chk_d;
      done_q <= done_d;
      addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    key_q     <= key_d;
    res_q     <= res_d;
  end

  assign rd_addr_o = addr_q;
  assign done_o    = done_q;
  assign res_o     = res_q;

  `KVBA_ASSERT_IMP(a_done_idle, done_q, !busy_q && !chk_q, "scan done while still busy")
  `KVBA_ASSERT_IMP(a_start_idle, start_i, !busy_q && !chk_q, "scan started while busy")
  `KVBA_ASSERT_IMP(a_chk_follows_busy, chk_q, $past(busy_q), "entry checked without a read")

endmodule
`default_nettype wire

[rtl/core/kv_block_allocator_prefix_cache.sv]
// Top level of the reference-counted block allocator with prefix-hash map.
// Usage:
// Commands arrive on the input channel (in_valid_i/in_ready_o) and each one
// produces exactly one result transaction on the output channel
// (out_valid_o/out_ready_i). One command is worked on at a time.
// After reset the block runs a clearing pass that fills the free stack with
// ascending ids and clears all counts, hashes and map entries; in_ready_o
// stays low during that pass.
// Lookup and insert scan every map entry with one comparator, and so does a
// free that releases a hashed block; the scan through the single map read
// port makes these the slowest commands.
// The next command can be accepted in the cycle after a result is loaded.
// A finished result sits in an output register; the next command is accepted
// while that result waits. If the receiver stalls, a second result waits in
// the sequencer until the output register is taken.
`default_nettype none
`include "assert_macros.svh"
module kv_block_allocator_prefix_cache (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [kvba_pkg::CMD_W-1:0]     command_i,
  input  logic [kvba_pkg::ID_W-1:0]      block_id_i,
  input  logic [kvba_pkg::KEY_W-1:0]     hash_in_i,
  input  logic [kvba_pkg::TOK_W-1:0]     token_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [kvba_pkg::STAT_W-1:0]    status_o,
  output logic [kvba_pkg::ID_W-1:0]      block_out_o,
  output logic [kvba_pkg::RC_W-1:0]      ref_count_out_o,
  output logic [kvba_pkg::KEY_W-1:0]     hash_out_o
);
  import kvba_pkg::*;

  state_e            state_q, state_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [TOK_W-1:0]  tok_q, tok_d;
  logic [FC_W-1:0]   fc_q, fc_d;
  logic [CLR_AW-1:0] clr_q, clr_d;
  blk_entry_t        ent_q, ent_d;

  // Result being built by the sequencer.
  status_e           rst_q, rst_d;
  logic [ID_W-1:0]   rblk_q, rblk_d;
  logic [RC_W-1:0]   rcnt_q, rcnt_d;
  logic [KEY_W-1:0]  rhash_q, rhash_d;

  // Output register.
  logic              ovld_q, ovld_d;
  status_e           ost_q, ost_d;
  logic [ID_W-1:0]   oblk_q, oblk_d;
  logic [RC_W-1:0]   ocnt_q, ocnt_d;
  logic [KEY_W-1:0]  ohash_q, ohash_d;

  // Memory ports.
  logic              stk_we;
  logic [BLK_AW-1:0] stk_waddr, stk_raddr;
  logic [BLK_AW-1:0] stk_wdata, stk_rdata;
  logic              blk_we;
  logic [BLK_AW-1:0] blk_waddr, blk_raddr;
  blk_entry_t        blk_wdata, blk_rdata;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  map_entry_t        map_wdata, map_rdata;

  // Scanner.
  logic              scan_start;
  logic [KEY_W-1:0]  scan_key;
  logic              scan_done;
  scan_res_t         scan_res;

  logic              id_bad;
  logic [FC_W-1:0]   fc_dec;
  logic [RC_W-1:0]   cnt_inc;

  assign id_bad  = {1'b0, id_q} >= (ID_W + 1)'(NUM_BLOCKS);
  assign fc_dec  = fc_q - 1'b1;
  assign cnt_inc = (blk_rdata.cnt == RC_MAX) ? blk_rdata.cnt : blk_rdata.cnt + 1'b1;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    id_d       = id_q;
    key_d      = key_q;
    tok_d      = tok_q;
    fc_d       = fc_q;
    clr_d      = clr_q;
    ent_d      = ent_q;
    rst_d      = rst_q;
    rblk_d     = rblk_q;
    rcnt_d     = rcnt_q;
    rhash_d    = rhash_q;
    ovld_d     = ovld_q && !out_ready_i;
    ost_d      = ost_q;
    oblk_d     = oblk_q;
    ocnt_d     = ocnt_q;
    ohash_d    = ohash_q;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_raddr  = '0;
    blk_we     = 1'b0;
    blk_waddr  = '0;
    blk_wdata  = '0;
    blk_raddr  = '0;
    map_we     = 1'b0;
    map_waddr  = '0;
    map_wdata  = '0;
    scan_start = 1'b0;
    scan_key   = key_q;

    unique case (state_q)
      S_CLEAR: begin
        // One row of every memory per cycle: ascending ids on the stack.
        if ({1'b0, clr_q} < (CLR_AW + 1)'(NUM_BLOCKS)) begin
          stk_we    = 1'b1;
          stk_waddr = clr_q[BLK_AW-1:0];
          stk_wdata = clr_q[BLK_AW-1:0];
          blk_we    = 1'b1;
          blk_waddr = clr_q[BLK_AW-1:0];
        end
        if ({1'b0, clr_q} < (CLR_AW + 1)'(MAP_ENTRIES)) begin
          map_we    = 1'b1;
          map_waddr = clr_q[MAP_AW-1:0];
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_AW'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          id_d    = block_id_i;
          key_d   = hash_in_i;
          tok_d   = token_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        rst_d   = ST_OK;
        rblk_d  = '0;
        rcnt_d  = '0;
        rhash_d = '0;
        unique case (cmd_q)
          CMD_ALLOC: begin
            if (fc_q == '0) begin
              rst_d   = ST_MISS;
              state_d = S_RESP;
            end else begin
              fc_d      = fc_dec;
              stk_raddr = fc_dec[BLK_AW-1:0];
              state_d   = S_STK_DATA;
            end
          end
          CMD_HASH: begin
            // Times 31 as a shift and a subtract; the token is added next.
            rhash_d = (key_q << 5) - key_q;
            state_d = S_HASH;
          end
          CMD_LOOKUP: begin
            scan_start = 1'b1;
            state_d    = S_SCAN_WAIT;
          end
          CMD_FREE, CMD_REF, CMD_INSERT: begin
            if (id_bad) begin
              rst_d   = ST_IGN;
              state_d = S_RESP;
            end else begin
              blk_raddr = id_q[BLK_AW-1:0];
              state_d   = S_BLK_DATA;
            end
          end
          default: begin
            rst_d   = ST_IGN;
            state_d = S_RESP;
          end
        endcase
      end
      S_HASH: begin
        rhash_d = rhash_q + KEY_W'(tok_q);
        state_d = S_RESP;
      end
      S_STK_DATA: begin
        blk_we         = 1'b1;
        blk_waddr      = stk_rdata;
        blk_wdata.cnt  = RC_W'(1);
        blk_wdata.hash = '0;
        rblk_d         = ID_W'(stk_rdata);
        rcnt_d         = RC_W'(1);
        state_d        = S_RESP;
      end
      S_BLK_DATA: begin
        ent_d   = blk_rdata;
        state_d = S_RESP;
        unique case (cmd_q)
          CMD_REF: begin
            blk_we         = 1'b1;
            blk_waddr      = id_q[BLK_AW-1:0];
            blk_wdata.cnt  = cnt_inc;
            blk_wdata.hash = blk_rdata.hash;
            rcnt_d         = cnt_inc;
          end
          CMD_FREE: begin
            if (blk_rdata.cnt == '0) begin
              rst_d = ST_IGN;
            end else if (blk_rdata.cnt != RC_W'(1)) begin
              blk_we         = 1'b1;
              blk_waddr      = id_q[BLK_AW-1:0];
              blk_wdata.cnt  = blk_rdata.cnt - 1'b1;
              blk_wdata.hash = blk_rdata.hash;
              rcnt_d         = blk_rdata.cnt - 1'b1;
            end else if (blk_rdata.hash != '0) begin
              // Last reference of a hashed block: find its map entry first.
              scan_start = 1'b1;
              scan_key   = blk_rdata.hash;
              state_d    = S_SCAN_WAIT;
            end else begin
              state_d = S_FREE_FIN;
            end
          end
          CMD_INSERT: begin
            rcnt_d     = blk_rdata.cnt;
            scan_start = 1'b1;
            state_d    = S_SCAN_WAIT;
          end
          default: begin
            rst_d = ST_IGN;
          end
        endcase
      end
      S_SCAN_WAIT: begin
        if (scan_done) begin
          state_d = S_RESP;
          unique case (cmd_q)
            CMD_LOOKUP: begin
              if (scan_res.hit) begin
                blk_raddr = scan_res.hit_blk;
                state_d   = S_LK_DATA;
              end else begin
                rst_d = ST_MISS;
              end
            end
            CMD_FREE: begin
              if (scan_res.hit && (scan_res.hit_blk == id_q[BLK_AW-1:0])) begin
                map_we    = 1'b1;
                map_waddr = scan_res.hit_idx;
              end
              state_d = S_FREE_FIN;
            end
            CMD_INSERT: begin
              if (scan_res.hit || scan_res.free_ok) begin
                map_we          = 1'b1;
                map_waddr       = scan_res.hit ? scan_res.hit_idx : scan_res.free_idx;
                map_wdata.valid = 1'b1;
                map_wdata.blk   = id_q[BLK_AW-1:0];
                map_wdata.key   = key_q;
                blk_we          = 1'b1;
                blk_waddr       = id_q[BLK_AW-1:0];
                blk_wdata.cnt   = ent_q.cnt;
                blk_wdata.hash  = key_q;
              end else begin
                rst_d = ST_FULL;
              end
            end
            default: begin
              rst_d = ST_IGN;
            end
          endcase
        end
      end
      S_LK_DATA: begin
        rblk_d  = ID_W'(scan_res.hit_blk);
        rcnt_d  = blk_rdata.cnt;
        state_d = S_RESP;
      end
      S_FREE_FIN: begin
        blk_we    = 1'b1;
        blk_waddr = id_q[BLK_AW-1:0];
        rcnt_d    = '0;
        if (fc_q < FC_W'(NUM_BLOCKS)) begin
          stk_we    = 1'b1;
          stk_waddr = fc_q[BLK_AW-1:0];
          stk_wdata = id_q[BLK_AW-1:0];
          fc_d      = fc_q + 1'b1;
        end else begin
          rst_d = ST_FULL;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d  = 1'b1;
          ost_d   = rst_q;
          oblk_d  = rblk_q;
          ocnt_d  = rcnt_q;
          ohash_d = rhash_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      fc_q    <= FC_W'(NUM_BLOCKS);
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      fc_q    <= fc_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    id_q    <= id_d;
    key_q   <= key_d;
    tok_q   <= tok_d;
    ent_q   <= ent_d;
    rst_q   <= rst_d;
    rblk_q  <= rblk_d;
    rcnt_q  <= rcnt_d;
    rhash_q <= rhash_d;
    ost_q   <= ost_d;
    oblk_q  <= oblk_d;
    ocnt_q  <= ocnt_d;
    ohash_q <= ohash_d;
  end

  kvba_ram #(
    .WIDTH(BLK_AW),
    .DEPTH(NUM_BLOCKS)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  kvba_ram #(
    .WIDTH($bits(blk_entry_t)),
    .DEPTH(NUM_BLOCKS)
  ) u_block_ram (
    .clk_i  (clk_i),
    .we_i   (blk_we),
    .waddr_i(blk_waddr),
    .wdata_i(blk_wdata),
    .raddr_i(blk_raddr),
    .rdata_o(blk_rdata)
  );

  kvba_ram #(
    .WIDTH($bits(map_entry_t)),
    .DEPTH(MAP_ENTRIES)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  kvba_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .key_i    (scan_key),
    .rd_addr_o(map_raddr),
    .rd_data_i(map_rdata),
    .done_o   (scan_done),
    .res_o    (scan_res)
  );

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = ovld_q;
  assign status_o        = ost_q;
  assign block_out_o     = oblk_q;
  assign ref_count_out_o = ocnt_q;
  assign hash_out_o      = ohash_q;

  `KVBA_ASSERT(a_fc_range, fc_q <= FC_W'(NUM_BLOCKS), "free count above block count")
  `KVBA_ASSERT_IMP(a_scan_done_state, scan_done, state_q == S_SCAN_WAIT,
    "scan finished outside of the scan wait state")
  `KVBA_ASSERT_IMP(a_out_from_resp, $rose(ovld_q), $past(state_q) == S_RESP,
    "result loaded outside of the response state")

endmodule
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the prefix-cache block allocator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kvba_pkg::*;

  // Multiplier of the rolling prefix hash.
  localparam logic [KEY_W-1:0] HASH_MULT = 64'd31;
  // Cycles without any transaction before the run is declared hung. The
  // slowest legitimate gap is the clearing pass after reset or one full map
  // scan, plus a receiver stall.
  localparam int HANG_LIMIT = 20000;
  // Wait that covers the longest command, a full map scan, with a margin.
  localparam int SCAN_CYCLES = MAP_ENTRIES + 64;

  // One command as presented on the input channel.
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic [TOK_W-1:0] tok;
  } command_t;

  // One result as seen on the output channel.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   blk;
    logic [RC_W-1:0]   cnt;
    logic [KEY_W-1:0]  hash;
  } alloc_result_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [CMD_W-1:0] command_i;
  logic [ID_W-1:0] block_id_i;
  logic [KEY_W-1:0] hash_in_i;
  logic [TOK_W-1:0] token_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [STAT_W-1:0] status_o;
  logic [ID_W-1:0] block_out_o;
  logic [RC_W-1:0] ref_count_out_o;
  logic [KEY_W-1:0] hash_out_o;

  kv_block_allocator_prefix_cache dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .block_id_i     (block_id_i),
    .hash_in_i      (hash_in_i),
    .token_i        (token_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .block_out_o    (block_out_o),
    .ref_count_out_o(ref_count_out_o),
    .hash_out_o     (hash_out_o)
  );

  // Clock: 20 ns period.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ------------------------------------------------------------------
  // Shadow copy of the allocator state, kept in step with every accepted
  // command transaction.
  // ------------------------------------------------------------------
  logic [ID_W-1:0]  free_ids [NUM_BLOCKS];
  int               free_depth;
  logic [RC_W-1:0]  block_refs [NUM_BLOCKS];
  logic [KEY_W-1:0] block_prefix [NUM_BLOCKS];
  logic [KEY_W-1:0] slot_key [MAP_ENTRIES];
  logic [ID_W-1:0]  slot_block [MAP_ENTRIES];
  logic             slot_used [MAP_ENTRIES];

  command_t      pending_commands[$];
  alloc_result_t awaited_results[$];
  int            error_count;
  int            sender_idle_pct;
  int            receiver_stall_pct;
  int            quiet_cycles;
  bit            cmd_taken;

  function automatic int find_slot(input logic [KEY_W-1:0] k);
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      if (slot_used[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Advances the shadow state by one command and returns its result.
  function automatic alloc_result_t apply_command(input command_t c);
    alloc_result_t r;
    int slot;
    logic [ID_W-1:0] b;
    r = '0;
    case (c.cmd)
      CMD_ALLOC: begin
        if (free_depth == 0) begin
          r.status = ST_MISS;
        end else begin
          free_depth--;
          b = free_ids[free_depth];
          block_refs[b] = RC_W'(1);
          block_prefix[b] = '0;
          r.blk = b;
          r.cnt = RC_W'(1);
        end
      end
      CMD_HASH: r.hash = c.key * HASH_MULT + KEY_W'(c.tok);
      CMD_LOOKUP: begin
        slot = find_slot(c.key);
        if (slot < 0) begin
          r.status = ST_MISS;
        end else begin
          r.blk = slot_block[slot];
          r.cnt = block_refs[slot_block[slot]];
        end
      end
      CMD_FREE, CMD_REF, CMD_INSERT: begin
        if (c.id >= NUM_BLOCKS) begin
          r.status = ST_IGN;
        end else if (c.cmd == CMD_REF) begin
          if (block_refs[c.id] != RC_MAX) block_refs[c.id]++;
          r.cnt = block_refs[c.id];
        end else if (c.cmd == CMD_FREE) begin
          if (block_refs[c.id] == 0) begin
            r.status = ST_IGN;
          end else begin
            block_refs[c.id]--;
            if (block_refs[c.id] == 0) begin
              // Release: drop the map entry only if it still points here.
              if (block_prefix[c.id] != 0) begin
                slot = find_slot(block_prefix[c.id]);
                if (slot >= 0 && slot_block[slot] == c.id) slot_used[slot] = 1'b0;
              end
              block_prefix[c.id] = '0;
              if (free_depth < NUM_BLOCKS) begin
                free_ids[free_depth] = c.id;
                free_depth++;
              end else begin
                r.status = ST_FULL;
              end
            end
            r.cnt = block_refs[c.id];
          end
        end else begin
          // Insert overwrites the same key, else takes the lowest free slot.
          slot = find_slot(c.key);
          if (slot < 0) begin
            for (int j = 0; j < MAP_ENTRIES; j++) begin
              if (!slot_used[j]) begin
                slot = j;
                break;
              end
            end
          end
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            block_prefix[c.id] = c.key;
            slot_key[slot] = c.key;
            slot_block[slot] = c.id;
            slot_used[slot] = 1'b1;
          end
          r.cnt = block_refs[c.id];
        end
      end
      default: r.status = ST_IGN;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A command stays on the
  // port until the rising edge that accepts it.
  // ------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
      if (!in_valid_i || cmd_taken) begin
        cmd_taken = 1'b0;
        if (pending_commands.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          command_i  <= pending_commands[0].cmd;
          block_id_i <= pending_commands[0].id;
          hash_in_i  <= pending_commands[0].key;
          token_i    <= pending_commands[0].tok;
          in_valid_i <= 1'b1;
          void'(pending_commands.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: predicts on each accepted command transaction and checks each
  // accepted result transaction against the oldest prediction.
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    alloc_result_t want;
    command_t c;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        c.cmd = command_i;
        c.id  = block_id_i;
        c.key = hash_in_i;
        c.tok = token_i;
        awaited_results = {awaited_results, apply_command(c)};
        cmd_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no command outstanding: status %0d blk %0d",
                   $time, status_o, block_out_o);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
            error_count++;
          end
          if (block_out_o !== want.blk) begin
            $display("%0t: block_out expected %0d actual %0d", $time, want.blk,
                     block_out_o);
            error_count++;
          end
          if (ref_count_out_o !== want.cnt) begin
            $display("%0t: reference count expected %0d actual %0d", $time, want.cnt,
                     ref_count_out_o);
            error_count++;
          end
          if (hash_out_o !== want.hash) begin
            $display("%0t: hash_out expected %h actual %h", $time, want.hash,
                     hash_out_o);
            error_count++;
          end
        end
      end
      // Watchdog on cycles without any transaction.
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles > HANG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus.
  // ------------------------------------------------------------------
  logic [KEY_W-1:0] key_pool [8];

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                          input logic [KEY_W-1:0] key, input logic [TOK_W-1:0] tok);
    command_t c;
    c.cmd = cmd;
    c.id  = id;
    c.key = key;
    c.tok = tok;
    pending_commands = {pending_commands, c};
  endtask

  // Waits until every queued command is accepted and every result has come.
  task automatic drain;
    @(negedge clk_i);
    while (pending_commands.size() > 0 || in_valid_i || awaited_results.size() > 0)
      @(negedge clk_i);
  endtask

  // Random commands. Ids mostly fall near the top of the free stack, where
  // allocation hands blocks out, and keys mostly come from a small pool so
  // that lookups hit and inserts overwrite.
  task automatic random_commands(input int n);
    int pick;
    logic [ID_W-1:0] id;
    logic [KEY_W-1:0] key;
    logic [CMD_W-1:0] cmd;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 20) cmd = CMD_ALLOC;
      else if (pick < 42) cmd = CMD_FREE;
      else if (pick < 56) cmd = CMD_REF;
      else if (pick < 68) cmd = CMD_LOOKUP;
      else if (pick < 80) cmd = CMD_INSERT;
      else if (pick < 95) cmd = CMD_HASH;
      else cmd = CMD_W'($urandom_range(7, 6));
      pick = $urandom_range(99);
      if (pick < 80) id = ID_W'(NUM_BLOCKS - 1 - $urandom_range(15));
      else if (pick < 90) id = ID_W'($urandom_range(NUM_BLOCKS - 1));
      else id = ID_W'($urandom_range(4095));
      if ($urandom_range(99) < 75) key = key_pool[$urandom_range(7)];
      else key = {$urandom, $urandom};
      push_cmd(cmd, id, key, $urandom);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    command_i = '0;
    block_id_i = '0;
    hash_in_i = '0;
    token_i = '0;
    error_count = 0;
    quiet_cycles = 0;
    cmd_taken = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      free_ids[i] = ID_W'(i);
      block_refs[i] = '0;
      block_prefix[i] = '0;
    end
    free_depth = NUM_BLOCKS;
    for (int i = 0; i < MAP_ENTRIES; i++) begin
      slot_key[i] = '0;
      slot_block[i] = '0;
      slot_used[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom | 32'd1};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, no idling. A block referenced while free and then
    // released finds the stack already full.
    push_cmd(CMD_REF, ID_W'(5), '0, '0);
    push_cmd(CMD_FREE, ID_W'(5), '0, '0);
    push_cmd(CMD_FREE, ID_W'(5), '0, '0);       // count zero: ignored
    push_cmd(CMD_ALLOC, '0, '0, '0);
    push_cmd(CMD_INSERT, ID_W'(NUM_BLOCKS - 1), key_pool[0], '0);
    push_cmd(CMD_LOOKUP, '0, key_pool[0], '0);
    push_cmd(CMD_LOOKUP, '0, key_pool[1], '0);  // miss
    push_cmd(CMD_INSERT, ID_W'(NUM_BLOCKS - 2), key_pool[0], '0);  // same key overwrites
    push_cmd(CMD_FREE, ID_W'(NUM_BLOCKS - 1), '0, '0); // entry now belongs elsewhere
    push_cmd(CMD_LOOKUP, '0, key_pool[0], '0);
    push_cmd(CMD_HASH, '1, '1, '1);
    push_cmd(CMD_HASH, '0, '0, '0);
    push_cmd(CMD_REF, ID_W'(4095), '1, '1);     // id out of range
    push_cmd(CMD_FREE, ID_W'(NUM_BLOCKS), '0, '0);
    push_cmd(CMD_INSERT, ID_W'(4095), key_pool[2], '0);
    push_cmd(CMD_W'(6), '0, '0, '0);
    push_cmd(CMD_W'(7), '1, '1, '1);
    push_cmd(CMD_INSERT, ID_W'(3), '0, '0);     // zero key
    push_cmd(CMD_LOOKUP, '0, '0, '0);
    push_cmd(CMD_ALLOC, '0, '0, '0);
    push_cmd(CMD_INSERT, ID_W'(NUM_BLOCKS - 1), key_pool[1], '0);
    push_cmd(CMD_FREE, ID_W'(NUM_BLOCKS - 1), '0, '0); // releases its own entry
    push_cmd(CMD_LOOKUP, '0, key_pool[1], '0);
    drain();

    // Random part in four idling phases; each phase drains before the next,
    // so the sender pauses until every result is back.
    random_commands(140);
    drain();
    sender_idle_pct = 84;
    random_commands(140);
    drain();
    sender_idle_pct = 0;
    receiver_stall_pct = 84;
    random_commands(140);
    drain();
    sender_idle_pct = 35;
    receiver_stall_pct = 35;
    random_commands(140);
    drain();

    repeat (SCAN_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/kvba_pkg.sv
rtl/core/kvba_ram.sv
rtl/core/kvba_scan.sv
rtl/core/kv_block_allocator_prefix_cache.sv
test/tb_top.sv
